FILE: sv/ctd_pkg.sv
// ----------------------------------------------------------------------------
// ctd_pkg: shared types and constants for the clap transient detector
// Register map, reset values, controller states and the command and status
// groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package ctd_pkg;

  localparam int CFG_W  = 16;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  // shared multiplier: 17-bit signed coefficient times 33-bit signed operand
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef logic [IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_NOISE_SMOOTHING  = 3'd0;
  localparam cfg_idx_t REG_OFFSET_SMOOTHING = 3'd1;
  localparam cfg_idx_t REG_THRESHOLD_GAIN   = 3'd2;
  localparam cfg_idx_t REG_PEAK_MINIMUM     = 3'd3;
  localparam cfg_idx_t REG_AVERAGE_MINIMUM  = 3'd4;
  localparam cfg_idx_t REG_HOLDOFF_MS       = 3'd5;

  localparam logic [CFG_W-1:0] RST_NOISE_SMOOTHING  = 16'd64225;
  localparam logic [CFG_W-1:0] RST_OFFSET_SMOOTHING = 16'd65208;
  localparam logic [CFG_W-1:0] RST_THRESHOLD_GAIN   = 16'd1024;
  localparam logic [CFG_W-1:0] RST_PEAK_MINIMUM     = 16'd1800;
  localparam logic [CFG_W-1:0] RST_AVERAGE_MINIMUM  = 16'd350;
  localparam logic [CFG_W-1:0] RST_HOLDOFF_MS       = 16'd180;

  // noise floor after reset: average_minimum reset value in Q16.16
  localparam logic [31:0] FLOOR_RESET = {RST_AVERAGE_MINIMUM, 16'd0};

  typedef struct packed {
    logic [CFG_W-1:0] noise_smoothing;
    logic [CFG_W-1:0] offset_smoothing;
    logic [CFG_W-1:0] threshold_gain;
    logic [CFG_W-1:0] peak_minimum;
    logic [CFG_W-1:0] average_minimum;
    logic [CFG_W-1:0] holdoff_ms;
  } ctd_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_OFFSET,
    ST_OFFSET,
    ST_ACCUM,
    ST_DIVIDE,
    ST_MUL_FLOOR,
    ST_FLOOR,
    ST_MUL_GAIN,
    ST_DECIDE
  } ctd_state_t;

  typedef enum logic [1:0] {
    MUL_OFFSET,
    MUL_FLOOR,
    MUL_GAIN
  } ctd_mul_sel_t;

  typedef struct packed {
    logic         load;
    logic         mul_en;
    ctd_mul_sel_t mul_sel;
    logic         offset_upd;
    logic         accum;
    logic         div_step;
    logic         floor_upd;
    logic         decide;
  } ctd_cmd_t;

  typedef struct packed {
    logic last;
    logic div_last;
    logic out_busy;
  } ctd_stat_t;

endpackage

FILE: sv/ctd_sample_if.sv
// ----------------------------------------------------------------------------
// ctd_sample_if: sample channel
// Valid/ready channel carrying one PCM sample with its block marker and time.
// ----------------------------------------------------------------------------
interface ctd_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic               end_of_block;
  logic [31:0]        time_ms;

  modport source (output valid, pcm_sample, end_of_block, time_ms, input ready);
  modport sink   (input valid, pcm_sample, end_of_block, time_ms, output ready);
endinterface

FILE: sv/ctd_result_if.sv
// ----------------------------------------------------------------------------
// ctd_result_if: result channel
// Valid/ready channel carrying one per-block detection result.
// ----------------------------------------------------------------------------
interface ctd_result_if;
  logic        valid;
  logic        ready;
  logic        clap_found;
  logic [15:0] block_peak_level;
  logic [15:0] block_mean_level;
  logic [15:0] floor_level;

  modport source (output valid, clap_found, block_peak_level, block_mean_level,
                  floor_level, input ready);
  modport sink   (input valid, clap_found, block_peak_level, block_mean_level,
                  floor_level, output ready);
endinterface

FILE: sv/ctd_ctrl.sv
// ----------------------------------------------------------------------------
// ctd_ctrl: detector sequencer
// Steps the datapath through the per-sample offset update and accumulation,
// and at block end through the serial divide, floor update and decision.
// ----------------------------------------------------------------------------
module ctd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ctd_pkg::ctd_stat_t stat,
  output ctd_pkg::ctd_cmd_t  cmd
);
  import ctd_pkg::*;

  ctd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (in_valid) state_next = ST_MUL_OFFSET;
      ST_MUL_OFFSET: state_next = ST_OFFSET;
      ST_OFFSET:     state_next = ST_ACCUM;
      ST_ACCUM:      state_next = stat.last ? ST_DIVIDE : ST_IDLE;
      ST_DIVIDE:     if (stat.div_last) state_next = ST_MUL_FLOOR;
      ST_MUL_FLOOR:  state_next = ST_FLOOR;
      ST_FLOOR:      state_next = ST_MUL_GAIN;
      ST_MUL_GAIN:   state_next = ST_DECIDE;
      ST_DECIDE:     if (!stat.out_busy) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mul_sel = MUL_OFFSET;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL_OFFSET: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_OFFSET;
      end
      ST_OFFSET:    cmd.offset_upd = 1'b1;
      ST_ACCUM:     cmd.accum = 1'b1;
      ST_DIVIDE:    cmd.div_step = 1'b1;
      ST_MUL_FLOOR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FLOOR;
      end
      ST_FLOOR:     cmd.floor_upd = 1'b1;
      ST_MUL_GAIN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN;
      end
      ST_DECIDE:    cmd.decide = !stat.out_busy;
      default:      cmd = '0;
    endcase
  end

endmodule

FILE: sv/ctd_datapath.sv
// ----------------------------------------------------------------------------
// ctd_datapath: detector arithmetic
// Offset tracking, level sum and peak, restoring divider for the block mean,
// noise floor, threshold compare and the result output register.
// ----------------------------------------------------------------------------
module ctd_datapath #(
  parameter int MAX_BLOCK = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  ctd_pkg::ctd_cfg_t  cfg,
  input  ctd_pkg::ctd_cmd_t  cmd,
  output ctd_pkg::ctd_stat_t stat,
  input  logic signed [15:0] pcm_sample,
  input  logic               end_of_block,
  input  logic [31:0]        time_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               clap_found,
  output logic [15:0]        block_peak_level,
  output logic [15:0]        block_mean_level,
  output logic [15:0]        floor_level
);
  import ctd_pkg::*;

  localparam int CW  = $clog2(MAX_BLOCK + 1);
  localparam int SW  = 32 + CW;
  localparam int DCW = $clog2(SW);
  localparam int EW  = PROD_W + 1;

  logic signed [15:0]        sample;
  logic                      last_flag;
  logic [31:0]               time_q;
  logic signed [31:0]        offset_est;
  logic [31:0]               floor_est;
  logic [31:0]               last_clap;
  logic [SW-1:0]             level_sum;
  logic [31:0]               level_peak;
  logic [CW-1:0]             blk_count;
  logic [CW-1:0]             rem;
  logic [DCW-1:0]            div_cnt;
  logic signed [PROD_W-1:0]  prod;

  logic signed [31:0]        x_w;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  product_w;
  logic signed [EW-1:0]      est_sum_w;
  logic [EW-1:0]             floor_sum_w;
  logic signed [32:0]        diff_w;
  logic [32:0]               diff_abs_w;
  logic [31:0]               mag_w;
  logic [31:0]               mean_w;
  logic [CW:0]               rem_sh_w;
  logic                      ge_w;
  logic [CW:0]               rem_new_w;
  logic [39:0]               thr_w;
  logic [31:0]               elapsed_w;
  logic                      clap_w;

  assign x_w = {sample, 16'd0};

  // quotient lands in level_sum after the divide; an empty block reads as zero
  assign mean_w = (blk_count == '0) ? 32'd0 : level_sum[31:0];

  always_comb begin
    case (cmd.mul_sel)
      MUL_OFFSET: begin
        mul_a = {1'b0, cfg.offset_smoothing};
        mul_b = {offset_est[31], offset_est} - {x_w[31], x_w};
      end
      MUL_FLOOR: begin
        mul_a = {1'b0, cfg.noise_smoothing};
        mul_b = {1'b0, floor_est} - {1'b0, mean_w};
      end
      MUL_GAIN: begin
        mul_a = {1'b0, cfg.threshold_gain};
        mul_b = {1'b0, floor_est};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product_w = mul_a * mul_b;

  // est' = (x*2^16 + d*(est - x) + 2^15) >> 16, floor division
  assign est_sum_w = {{3{x_w[31]}}, x_w, 16'd0} + {prod[PROD_W-1], prod}
                   + EW'(32768);
  // floor' = (mean*2^16 + a*(floor - mean) + 2^15) >> 16
  assign floor_sum_w = {3'd0, mean_w, 16'd0} + {prod[PROD_W-1], prod}
                     + EW'(32768);

  assign diff_w     = {x_w[31], x_w} - {offset_est[31], offset_est};
  assign diff_abs_w = diff_w[32] ? -diff_w : diff_w;
  assign mag_w      = diff_abs_w[31:0];

  // restoring divide, one quotient bit per cycle
  assign rem_sh_w  = {rem, level_sum[SW-1]};
  assign ge_w      = rem_sh_w >= {1'b0, blk_count};
  assign rem_new_w = ge_w ? rem_sh_w - {1'b0, blk_count} : rem_sh_w;

  assign thr_w     = prod[47:8];
  assign elapsed_w = time_q - last_clap;
  assign clap_w    = (elapsed_w >= {16'd0, cfg.holdoff_ms})
                  && ({8'd0, level_peak} >= thr_w)
                  && (level_peak >= {cfg.peak_minimum, 16'd0})
                  && (mean_w >= {cfg.average_minimum, 16'd0});

  assign stat.last     = last_flag;
  assign stat.div_last = (div_cnt == DCW'(SW - 1));
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample    <= pcm_sample;
      last_flag <= end_of_block;
      time_q    <= time_ms;
    end
    if (cmd.mul_en) begin
      prod <= product_w;
    end
    if (cmd.decide) begin
      clap_found       <= clap_w;
      block_peak_level <= level_peak[31:16];
      block_mean_level <= mean_w[31:16];
      floor_level      <= floor_est[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_est   <= '0;
      floor_est    <= FLOOR_RESET;
      last_clap    <= '0;
      level_sum    <= '0;
      level_peak   <= '0;
      blk_count    <= '0;
      rem          <= '0;
      div_cnt      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.offset_upd) begin
        offset_est <= est_sum_w[47:16];
      end
      if (cmd.accum) begin
        if (blk_count < CW'(MAX_BLOCK)) begin
          level_sum    <= level_sum + {{CW{1'b0}}, mag_w};
          blk_count    <= blk_count + 1'b1;
        end
        if (mag_w > level_peak) begin
          level_peak <= mag_w;
        end
        rem     <= '0;
        div_cnt <= '0;
      end
      if (cmd.div_step) begin
        rem       <= rem_new_w[CW-1:0];
        level_sum <= {level_sum[SW-2:0], ge_w};
        div_cnt   <= div_cnt + 1'b1;
      end
      if (cmd.floor_upd) begin
        floor_est <= floor_sum_w[47:16];
      end
      if (cmd.decide) begin
        if (clap_w) begin
          last_clap <= time_q;
        end
        level_sum    <= '0;
        level_peak   <= '0;
        blk_count    <= '0;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/clap_transient_detector_core.sv
// ----------------------------------------------------------------------------
// clap_transient_detector_core: clap detector with adaptive noise floor
// Top level: APB register file, sequencer and datapath.
// ----------------------------------------------------------------------------
// Each sample item goes through accept, offset multiply, offset update and
// level accumulate; the last item of a block then adds a serial divide, floor
// multiply, floor update, gain multiply and decision. The pace is set by the
// one-bit-per-cycle mean divider and the shared multiplier used for the
// offset, floor and threshold. The result sits in an output register, so the
// next block's samples are taken while it waits; a block end only stalls if
// the previous result has still not been taken. Registers must be written
// over APB only while the block is idle; the block itself does not enforce
// this. Registers sit at byte 4*index.
module clap_transient_detector_core #(
  parameter int MAX_BLOCK = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  ctd_sample_if.sink                   sample_ch,
  ctd_result_if.source                 result_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ctd_pkg::ADDR_W-1:0]   paddr,
  input  logic [ctd_pkg::DATA_W-1:0]   pwdata,
  output logic [ctd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import ctd_pkg::*;

  ctd_cfg_t  cfg;
  ctd_cmd_t  cmd;
  ctd_stat_t stat;
  cfg_idx_t  reg_idx;
  logic      in_ready;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[IDX_W+1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.noise_smoothing  <= RST_NOISE_SMOOTHING;
      cfg.offset_smoothing <= RST_OFFSET_SMOOTHING;
      cfg.threshold_gain   <= RST_THRESHOLD_GAIN;
      cfg.peak_minimum     <= RST_PEAK_MINIMUM;
      cfg.average_minimum  <= RST_AVERAGE_MINIMUM;
      cfg.holdoff_ms       <= RST_HOLDOFF_MS;
    end else if (wr_en) begin
      case (reg_idx)
        REG_NOISE_SMOOTHING:  cfg.noise_smoothing  <= pwdata[CFG_W-1:0];
        REG_OFFSET_SMOOTHING: cfg.offset_smoothing <= pwdata[CFG_W-1:0];
        REG_THRESHOLD_GAIN:   cfg.threshold_gain   <= pwdata[CFG_W-1:0];
        REG_PEAK_MINIMUM:     cfg.peak_minimum     <= pwdata[CFG_W-1:0];
        REG_AVERAGE_MINIMUM:  cfg.average_minimum  <= pwdata[CFG_W-1:0];
        REG_HOLDOFF_MS:       cfg.holdoff_ms       <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NOISE_SMOOTHING:  prdata = {16'd0, cfg.noise_smoothing};
      REG_OFFSET_SMOOTHING: prdata = {16'd0, cfg.offset_smoothing};
      REG_THRESHOLD_GAIN:   prdata = {16'd0, cfg.threshold_gain};
      REG_PEAK_MINIMUM:     prdata = {16'd0, cfg.peak_minimum};
      REG_AVERAGE_MINIMUM:  prdata = {16'd0, cfg.average_minimum};
      REG_HOLDOFF_MS:       prdata = {16'd0, cfg.holdoff_ms};
      default:              prdata = '0;
    endcase
  end

  assign sample_ch.ready = in_ready;

  ctd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ctd_datapath #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .pcm_sample       (sample_ch.pcm_sample),
    .end_of_block     (sample_ch.end_of_block),
    .time_ms          (sample_ch.time_ms),
    .out_valid        (result_ch.valid),
    .out_ready        (result_ch.ready),
    .clap_found       (result_ch.clap_found),
    .block_peak_level (result_ch.block_peak_level),
    .block_mean_level (result_ch.block_mean_level),
    .floor_level      (result_ch.floor_level)
  );

endmodule

FILE: sv/ctd_checker.sv
// ----------------------------------------------------------------------------
// ctd_checker: port-level checks for the clap detector
// Watches the channel handshakes and the reset behavior on the top level.
// ----------------------------------------------------------------------------
module ctd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        clap_found,
  input logic [15:0] block_peak_level,
  input logic [15:0] block_mean_level,
  input logic [15:0] floor_level
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(clap_found)
      && $stable(block_peak_level) && $stable(block_mean_level)
      && $stable(floor_level))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous item still in work");

  // a block result needs the full divide, never right after an accept
  a_no_quick_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result raised right after an item");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind clap_transient_detector_core ctd_checker u_ctd_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (sample_ch.valid),
  .in_ready         (sample_ch.ready),
  .out_valid        (result_ch.valid),
  .out_ready        (result_ch.ready),
  .clap_found       (result_ch.clap_found),
  .block_peak_level (result_ch.block_peak_level),
  .block_mean_level (result_ch.block_mean_level),
  .floor_level      (result_ch.floor_level)
);

FILE: test/clap_transient_detector_core_tb.sv
// ----------------------------------------------------------------------------
// clap_transient_detector_core_tb: self-checking bench for the clap detector
// Streams PCM blocks through the sample channel with random gaps and result
// stalls, programs the registers over APB between phases, and compares every
// block result against a cycle-free fixed-point model of the detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module clap_transient_detector_core_tb;
  import ctd_pkg::*;

  localparam int MAX_BLOCK      = 1024;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 50;

  // register indexes with no register behind them
  localparam cfg_idx_t SPARE_IDX_LO = cfg_idx_t'(REG_HOLDOFF_MS + 3'd1);
  localparam cfg_idx_t SPARE_IDX_HI = '1;

  typedef struct packed {
    logic signed [15:0] pcm;
    logic               eob;
    logic [31:0]        t_ms;
  } pcm_item_t;

  typedef struct packed {
    logic        clap;
    logic [15:0] peak;
    logic [15:0] mean;
    logic [15:0] floor_lvl;
  } block_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  ctd_sample_if sample_ch();
  ctd_result_if result_ch();

  clap_transient_detector_core #(.MAX_BLOCK(MAX_BLOCK)) dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  pcm_item_t     pending_samples[$];
  block_result_t expected_blocks[$];
  int            error_count = 0;
  bit            send_idle = 1'b1;
  bit            recv_idle = 1'b1;
  int            gap_left = 0;
  int            stall_left = 0;
  int            idle_cycles = 0;

  // detector model state
  logic [15:0]        cfg_regs [0:5];
  logic signed [31:0] dc_level = '0;
  logic [31:0]        floor_q = FLOOR_RESET;
  logic [31:0]        prev_clap_t = '0;
  logic [63:0]        level_total = '0;
  logic [31:0]        level_max = '0;
  int                 level_count = 0;

  initial begin
    cfg_regs[REG_NOISE_SMOOTHING]  = RST_NOISE_SMOOTHING;
    cfg_regs[REG_OFFSET_SMOOTHING] = RST_OFFSET_SMOOTHING;
    cfg_regs[REG_THRESHOLD_GAIN]   = RST_THRESHOLD_GAIN;
    cfg_regs[REG_PEAK_MINIMUM]     = RST_PEAK_MINIMUM;
    cfg_regs[REG_AVERAGE_MINIMUM]  = RST_AVERAGE_MINIMUM;
    cfg_regs[REG_HOLDOFF_MS]       = RST_HOLDOFF_MS;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic int draw_wait(input bit enable);
    return enable ? $urandom_range(0, 11) : 0;
  endfunction

  // Advance the detector model by one accepted sample; a block end queues
  // the expected result.
  task automatic track_sample(input pcm_item_t it);
    longint        x, acc, rounded, diff;
    logic [31:0]   mag, mean_q, elapsed;
    logic [63:0]   fl, thr;
    block_result_t r;
    x = longint'(it.pcm) * 65536;
    acc = longint'(cfg_regs[REG_OFFSET_SMOOTHING]) * longint'(dc_level)
        + (65536 - longint'(cfg_regs[REG_OFFSET_SMOOTHING])) * x;
    // round half up, floor semantics for negatives
    rounded = (acc + 32768) >>> 16;
    dc_level = 32'(rounded);
    diff = x - longint'(dc_level);
    mag = 32'((diff < 0) ? -diff : diff);
    // past MAX_BLOCK the mean is frozen, only the peak keeps tracking
    if (level_count < MAX_BLOCK) begin
      level_total += 64'(mag);
      level_count++;
    end
    if (mag > level_max) level_max = mag;
    if (it.eob) begin
      mean_q = (level_count != 0) ? 32'(level_total / level_count) : 32'd0;
      fl = (64'(cfg_regs[REG_NOISE_SMOOTHING]) * 64'(floor_q)
          + (64'd65536 - 64'(cfg_regs[REG_NOISE_SMOOTHING])) * 64'(mean_q)
          + 64'd32768) >> 16;
      floor_q = fl[31:0];
      // full-width threshold, no wrap with a large gain
      thr = (64'(floor_q) * 64'(cfg_regs[REG_THRESHOLD_GAIN])) >> 8;
      if (thr < 64'({cfg_regs[REG_PEAK_MINIMUM], 16'd0}))
        thr = 64'({cfg_regs[REG_PEAK_MINIMUM], 16'd0});
      elapsed = it.t_ms - prev_clap_t;
      r.clap = (elapsed >= 32'(cfg_regs[REG_HOLDOFF_MS])) && (64'(level_max) >= thr)
            && (mean_q >= {cfg_regs[REG_AVERAGE_MINIMUM], 16'd0});
      if (r.clap) prev_clap_t = it.t_ms;
      r.peak      = level_max[31:16];
      r.mean      = mean_q[31:16];
      r.floor_lvl = floor_q[31:16];
      expected_blocks.push_back(r);
      level_total = '0;
      level_max   = '0;
      level_count = 0;
    end
  endtask

  // sample driver
  always @(posedge clk) begin : send_side
    pcm_item_t it;
    if (rst) begin
      sample_ch.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        it.pcm  = sample_ch.pcm_sample;
        it.eob  = sample_ch.end_of_block;
        it.t_ms = sample_ch.time_ms;
        track_sample(it);
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (gap_left != 0) begin
          sample_ch.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_samples.size() != 0) begin
          it = pending_samples.pop_front();
          sample_ch.valid        <= 1'b1;
          sample_ch.pcm_sample   <= it.pcm;
          sample_ch.end_of_block <= it.eob;
          sample_ch.time_ms      <= it.t_ms;
          gap_left <= draw_wait(send_idle);
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready stalls
  always @(posedge clk) begin : recv_side
    block_result_t want;
    int w;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (result_ch.valid && result_ch.ready) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch("result with no pending block end");
      end else begin
        want = expected_blocks.pop_front();
        check_field("clap_found", 16'(result_ch.clap_found), 16'(want.clap));
        check_field("block_peak_level", result_ch.block_peak_level, want.peak);
        check_field("block_mean_level", result_ch.block_mean_level, want.mean);
        check_field("floor_level", result_ch.floor_level, want.floor_lvl);
      end
      w = draw_wait(recv_idle);
      if (w == 0) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b0;
        stall_left <= w - 1;
      end
    end else if (!result_ch.ready) begin
      if (stall_left == 0) result_ch.ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
        || (psel && penable && pwrite)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_sample(input int pcm, input bit eob, input logic [31:0] t_ms);
    pcm_item_t it;
    if (pcm > 32767) pcm = 32767;
    if (pcm < -32768) pcm = -32768;
    it.pcm  = 16'(pcm);
    it.eob  = eob;
    it.t_ms = t_ms;
    pending_samples.push_back(it);
  endtask

  // wait until every queued item went in and every result came back, then
  // give the block time to finish any block still in flight
  task automatic drain();
    do @(negedge clk);
    while (pending_samples.size() != 0 || sample_ch.valid || expected_blocks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input cfg_idx_t idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx <= REG_HOLDOFF_MS) cfg_regs[idx] = data[15:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper data bits carry junk, only the low 16 bits count
  task automatic write_all(input logic [15:0] noise, input logic [15:0] offs,
                           input logic [15:0] gain, input logic [15:0] pk_min,
                           input logic [15:0] avg_min, input logic [15:0] hold);
    apb_write(REG_NOISE_SMOOTHING,  {16'($urandom()), noise});
    apb_write(REG_OFFSET_SMOOTHING, {16'($urandom()), offs});
    apb_write(REG_THRESHOLD_GAIN,   {16'($urandom()), gain});
    apb_write(REG_PEAK_MINIMUM,     {16'($urandom()), pk_min});
    apb_write(REG_AVERAGE_MINIMUM,  {16'($urandom()), avg_min});
    apb_write(REG_HOLDOFF_MS,       {16'($urandom()), hold});
  endtask

  initial begin : stimulus
    int          blk_len, style, dc, amp, spike_at, v, budget, long_len;
    logic [31:0] now_ms;
    sample_ch.valid        = 1'b0;
    sample_ch.pcm_sample   = '0;
    sample_ch.end_of_block = 1'b0;
    sample_ch.time_ms      = '0;
    result_ch.ready        = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: extremes, holdoff edges, time wrap
    queue_sample(32767, 1'b1, 32'd200);
    queue_sample(-32768, 1'b1, 32'd250);
    queue_sample(0, 1'b1, 32'hFFFF_FFFF);
    queue_sample(32767, 1'b0, 32'hFFFF_FFFF);
    queue_sample(-32768, 1'b0, 32'h0000_0000);
    queue_sample(32767, 1'b1, 32'h0000_0010);
    queue_sample(-32768, 1'b1, 32'h0000_00C3);
    queue_sample(32767, 1'b1, 32'h0000_00C4);
    queue_sample(1, 1'b0, 32'h0000_0000);
    queue_sample(-1, 1'b1, 32'd500);
    queue_sample(0, 1'b1, 32'd1000);
    drain();

    // writes to unmapped indexes, which the design drops; write_all then rewrites every register
    apb_write(SPARE_IDX_LO, '1);
    apb_write(SPARE_IDX_HI, '1);
    write_all(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    queue_sample(100, 1'b1, 32'd5);
    queue_sample(-32768, 1'b0, 32'd7);
    queue_sample(32767, 1'b1, 32'd7);
    drain();

    // floor follows the mean, huge gain: threshold beyond 32 bits
    write_all(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    queue_sample(32767, 1'b0, 32'd0);
    queue_sample(-32768, 1'b1, 32'd9000);
    queue_sample(32767, 1'b1, 32'd9001);
    drain();

    write_all(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    queue_sample(-32768, 1'b0, 32'd0);
    queue_sample(32767, 1'b1, 32'd20);
    queue_sample(12345, 1'b1, 32'd20);
    drain();

    // one block past MAX_BLOCK with loud alternating content, no idling
    send_idle = 1'b0;
    recv_idle = 1'b0;
    write_all(16'($urandom()), 16'hFFFF, RST_THRESHOLD_GAIN, RST_PEAK_MINIMUM,
              RST_AVERAGE_MINIMUM, RST_HOLDOFF_MS);
    long_len = MAX_BLOCK + $urandom_range(1, 12);
    for (int i = 0; i < long_len; i++) begin
      v = $urandom_range(30000, 32767);
      if ($urandom_range(0, 15) == 0) v = $signed(16'($urandom()));
      else if (i % 2 == 1) v = -v - 1;
      queue_sample(v, i == long_len - 1, (i == long_len - 1) ? 32'd40000 : $urandom());
    end
    drain();

    now_ms = 32'd50000;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      send_idle = (ph == 1) ? 1'b0 : (ph == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      recv_idle = (ph == 1) ? 1'b0 : (ph == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (ph == 2) now_ms = 32'hFFFF_FF00;
      write_all(($urandom_range(0, 1) != 0) ? 16'($urandom()) : 16'($urandom_range(60000, 65535)),
                ($urandom_range(0, 2) != 0) ? 16'($urandom_range(60000, 65535)) : 16'($urandom()),
                ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 3000)) : 16'($urandom()),
                16'($urandom_range(0, 5000)), 16'($urandom_range(0, 1500)),
                16'($urandom_range(0, 400)));
      budget = PHASE_ITEMS;
      while (budget > 0) begin
        blk_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        style    = $urandom_range(0, 3);
        dc       = $urandom_range(0, 4000) - 2000;
        amp      = (style == 2) ? 3000 : 300;
        spike_at = $urandom_range(0, blk_len - 1);
        now_ms  += $urandom_range(0, 300);
        for (int i = 0; i < blk_len; i++) begin
          case (style)
            1: v = $signed(16'($urandom()));
            3: begin
              if (i == spike_at) v = $urandom_range(20000, 32767);
              else v = dc + $urandom_range(0, 2 * amp) - amp;
              if (i == spike_at && $urandom_range(0, 1) != 0) v = -v;
            end
            default: v = dc + $urandom_range(0, 2 * amp) - amp;
          endcase
          queue_sample(v, i == blk_len - 1, (i == blk_len - 1) ? now_ms : $urandom());
        end
        budget -= blk_len;
      end
      // sender holds until every block result is back
      drain();
    end

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/ctd_pkg.sv
sv/ctd_sample_if.sv
sv/ctd_result_if.sv
sv/ctd_ctrl.sv
sv/ctd_datapath.sv
sv/clap_transient_detector_core.sv
sv/ctd_checker.sv
test/clap_transient_detector_core_tb.sv
